@@ sv/cfd_pkg.sv @@
package cfd_pkg;

    // Framing characters and sizes
    localparam logic [7:0]  LEADER_CHAR     = 8'h40;
    localparam logic [7:0]  TYPE_CHAR       = 8'h43;
    localparam logic [7:0]  TYPE_ONE        = 8'h01;
    localparam logic [1:0]  LEADER_MAX      = 2'd3;
    localparam logic [2:0]  HEADER_LAST_IDX = 3'd6;
    localparam logic [2:0]  IDX_LEN_HI      = 3'd2;
    localparam logic [2:0]  IDX_LEN_LO      = 3'd3;
    localparam logic [2:0]  IDX_TYPE_C      = 3'd4;
    localparam logic [2:0]  IDX_TYPE_A      = 3'd5;
    localparam logic [2:0]  IDX_TYPE_B      = 3'd6;
    localparam logic [15:0] LENGTH_OVERHEAD = 16'd5;

    // Frame end status
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_LEADER_TO  = 3'd1,
        ST_NO_LEADER  = 3'd2,
        ST_HEADER_TO  = 3'd3,
        ST_BAD_TYPE   = 3'd4,
        ST_PAYLOAD_TO = 3'd5
    } status_t;

    // Input operation
    typedef enum logic {
        OP_BYTE  = 1'b0,
        OP_TIMER = 1'b1
    } op_t;

    typedef struct packed {
        op_t        operation;
        logic [7:0] rx_byte;
    } cfd_in_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] data_byte;
        logic       last;
        status_t    status;
    } cfd_out_t;

    // One processing step: result present flag plus the result
    typedef struct packed {
        logic     valid;
        cfd_out_t item;
    } cfd_step_t;

endpackage

@@ sv/cfd_in_stage.sv @@
module cfd_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  cfd_pkg::cfd_in_t in_data,
    input  logic            fire,
    output logic            item_valid,
    output cfd_pkg::cfd_in_t item
);
    import cfd_pkg::*;

    logic    valid_reg;
    cfd_in_t data_reg;

    // slot frees up in the same cycle the core consumes it
    assign in_ready   = !valid_reg || fire;
    assign item_valid = valid_reg;
    assign item       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

endmodule

@@ sv/cfd_core.sv @@
module cfd_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  cfd_pkg::cfd_in_t  item,
    output cfd_pkg::cfd_step_t step
);
    import cfd_pkg::*;

    typedef enum logic [1:0] {
        PH_LEADER  = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  leader_count_reg, leader_count_next;
    logic [2:0]  header_index_reg, header_index_next;
    logic [15:0] length_reg, length_next;
    logic        type_ok_reg, type_ok_next;
    logic [15:0] remaining_reg, remaining_next;

    logic [7:0]  b;
    logic        do_header;
    logic [2:0]  hidx;
    logic [15:0] hlen;
    logic        htype;
    logic [1:0]  lc_inc;

    // Step logic for one item
    always_comb
    begin
        phase_next        = phase_reg;
        leader_count_next = leader_count_reg;
        header_index_next = header_index_reg;
        length_next       = length_reg;
        type_ok_next      = type_ok_reg;
        remaining_next    = remaining_reg;
        step              = '0;

        b         = item.rx_byte;
        lc_inc    = leader_count_reg + 2'd1;
        do_header = 1'b0;
        hidx      = (phase_reg == PH_HEADER) ? header_index_reg : 3'd0;
        hlen      = length_reg;
        htype     = type_ok_reg;

        if (item.operation == OP_TIMER)
        begin
            step.valid     = 1'b1;
            step.item.last = 1'b1;
            case (phase_reg)
                PH_HEADER:  step.item.status = ST_HEADER_TO;
                PH_PAYLOAD: step.item.status = ST_PAYLOAD_TO;
                default:    step.item.status = ST_LEADER_TO;
            endcase
            phase_next        = PH_LEADER;
            leader_count_next = '0;
            header_index_next = '0;
            length_next       = '0;
            type_ok_next      = 1'b1;
            remaining_next    = '0;
        end
        else if (phase_reg == PH_HEADER)
        begin
            do_header = 1'b1;
        end
        else if (phase_reg == PH_PAYLOAD)
        begin
            step.valid          = 1'b1;
            step.item.has_byte  = 1'b1;
            step.item.data_byte = b;
            if (remaining_reg <= 16'd1)
            begin
                step.item.last    = 1'b1;
                step.item.status  = ST_OK;
                phase_next        = PH_LEADER;
                leader_count_next = '0;
                header_index_next = '0;
                length_next       = '0;
                type_ok_next      = 1'b1;
                remaining_next    = '0;
            end
            else
            begin
                remaining_next = remaining_reg - 16'd1;
            end
        end
        else if (b == LEADER_CHAR)
        begin
            leader_count_next = lc_inc;
            if (lc_inc >= LEADER_MAX)
            begin
                phase_next        = PH_HEADER;
                header_index_next = '0;
            end
        end
        else if (leader_count_reg == 2'd0)
        begin
            step.valid        = 1'b1;
            step.item.last    = 1'b1;
            step.item.status  = ST_NO_LEADER;
            phase_next        = PH_LEADER;
            leader_count_next = '0;
            header_index_next = '0;
            length_next       = '0;
            type_ok_next      = 1'b1;
            remaining_next    = '0;
        end
        else
        begin
            // short leader: this byte is the first CRC byte
            do_header = 1'b1;
        end

        // Header byte handling
        if (do_header)
        begin
            case (hidx)
                IDX_LEN_HI: hlen = {b, length_reg[7:0]};
                IDX_LEN_LO: hlen = {length_reg[15:8], b};
                IDX_TYPE_C: htype = type_ok_reg && (b == TYPE_CHAR);
                IDX_TYPE_A: htype = type_ok_reg && (b == TYPE_ONE);
                IDX_TYPE_B: htype = type_ok_reg && (b == TYPE_ONE);
                default:    hlen = length_reg;
            endcase
            phase_next        = PH_HEADER;
            header_index_next = hidx + 3'd1;
            length_next       = hlen;
            type_ok_next      = htype;
            if (hidx >= HEADER_LAST_IDX)
            begin
                if (!htype || (hlen <= LENGTH_OVERHEAD))
                begin
                    step.valid        = 1'b1;
                    step.item.last    = 1'b1;
                    step.item.status  = htype ? ST_OK : ST_BAD_TYPE;
                    phase_next        = PH_LEADER;
                    leader_count_next = '0;
                    header_index_next = '0;
                    length_next       = '0;
                    type_ok_next      = 1'b1;
                    remaining_next    = '0;
                end
                else
                begin
                    remaining_next = hlen - LENGTH_OVERHEAD;
                    phase_next     = PH_PAYLOAD;
                end
            end
        end
    end

    // Frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_LEADER;
            leader_count_reg <= '0;
            header_index_reg <= '0;
            length_reg       <= '0;
            type_ok_reg      <= 1'b1;
            remaining_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg        <= phase_next;
            leader_count_reg <= leader_count_next;
            header_index_reg <= header_index_next;
            length_reg       <= length_next;
            type_ok_reg      <= type_ok_next;
            remaining_reg    <= remaining_next;
        end
    end

    // a payload phase always has at least one byte to come
    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> remaining_reg != 16'd0)
        else $error("payload phase with zero bytes remaining");

    // leader phase always starts from a clean header context
    a_leader_clean: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LEADER |-> (length_reg == 16'd0) && type_ok_reg
                                   && (header_index_reg == 3'd0))
        else $error("leader phase with stale header state");

    // header index never runs past the last header byte
    a_header_index: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> header_index_reg <= HEADER_LAST_IDX)
        else $error("header index out of range");

    // an error end never carries a payload byte
    a_error_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        fire && step.valid && (step.item.status != ST_OK) |-> !step.item.has_byte)
        else $error("error status together with a data byte");

    // a frame end moves the state back to the leader phase
    a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
        fire && step.valid && step.item.last |=> phase_reg == PH_LEADER)
        else $error("frame end did not restart the frame");

endmodule

@@ sv/cfd_out_stage.sv @@
module cfd_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  cfd_pkg::cfd_step_t step,
    output logic               slot_free,
    output logic               out_valid,
    input  logic               out_ready,
    output cfd_pkg::cfd_out_t  out_data
);
    import cfd_pkg::*;

    logic     valid_reg;
    cfd_out_t data_reg;
    logic     load;

    // result register can take a new result when empty or being drained
    assign slot_free = !valid_reg || out_ready;
    assign load      = fire && step.valid;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= step.item;
        end
    end

endmodule

@@ sv/command_frame_deframer_unit.sv @@
// Command frame deframer.
// Input channel (in_valid/in_ready/in_data) carries one transaction per received
// byte, or a timer-expired marker (operation = 1). Output channel
// (out_valid/out_ready/out_data) carries payload bytes; each frame end (last = 1)
// carries the frame status, on the last payload byte or on a transaction of its own.
// Throughput: one input transaction per cycle, sustained, as long as the
// receiver keeps up; the frame state is updated combinationally (one compare,
// one 16-bit decrement) between the input register and the result register.
// A result passes through the input register, then the result register,
// before it is presented on out_valid.
// Input transactions that produce no result (leader and header bytes) still
// pass through the same pipeline slot.
// When the receiver stalls, the result register holds its transaction and the
// input register fills; in_ready then drops until out_ready returns.
// Reset clears both registers' valid flags and returns the frame state to
// waiting for a leader; no clearing pass is needed.
module command_frame_deframer_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cfd_pkg::cfd_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output cfd_pkg::cfd_out_t out_data
);
    import cfd_pkg::*;

    logic      item_valid;
    cfd_in_t   item;
    cfd_step_t step;
    logic      slot_free;
    logic      fire;

    // core consumes the held item when the result slot can take it
    assign fire = item_valid && slot_free;

    cfd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .fire       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    cfd_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item),
        .step  (step)
    );

    cfd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .step      (step),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    import cfd_pkg::*;

    localparam int ITEMS        = 1250;
    localparam int CALM_TAIL    = 150;
    localparam int HOLD_AT      = 300;
    localparam int PAUSE_AT     = 700;
    localparam int LONG_HOLD    = 64;
    localparam int DRAIN_CYCLES = 10;
    localparam int STUCK_LIMIT  = 2000;
    localparam int REPORT_MAX   = 10;

    typedef enum logic [1:0] {
        FR_LEADER  = 2'd0,
        FR_HEADER  = 2'd1,
        FR_PAYLOAD = 2'd2
    } frame_phase_t;

    // One row of the directed table; fixed rows carry their result inline
    typedef struct {
        cfd_in_t  item;
        bit       fixed;
        cfd_out_t result;
    } dir_row_t;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    cfd_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    cfd_out_t out_data;

    // Deframer shadow state
    frame_phase_t ph;
    logic [1:0]   lead_cnt;
    logic [2:0]   hdr_idx;
    logic [15:0]  frame_len;
    logic         type_good;
    logic [15:0]  pay_left;

    cfd_out_t deframed_q[$];
    dir_row_t dir_tab[$];

    bit       row_fixed;
    cfd_out_t row_fixed_out;
    cfd_out_t step_out;
    bit       step_has;
    cfd_out_t head_out;

    int  n_sent;
    int  n_bad;
    int  stuck_cycles;
    bit  calm;
    bit  hold_req;
    bit  hold_done;

    command_frame_deframer_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic cfd_in_t mk_item(op_t op, logic [7:0] b);
        cfd_in_t it;
        it.operation = op;
        it.rx_byte   = b;
        return it;
    endfunction

    function automatic cfd_out_t end_result(status_t st);
        cfd_out_t r;
        r.has_byte  = 1'b0;
        r.data_byte = 8'h00;
        r.last      = 1'b1;
        r.status    = st;
        return r;
    endfunction

    function automatic void frame_restart();
        ph        = FR_LEADER;
        lead_cnt  = 2'd0;
        hdr_idx   = 3'd0;
        frame_len = 16'd0;
        type_good = 1'b1;
        pay_left  = 16'd0;
    endfunction

    // Header byte: length capture, type check, frame end or payload entry
    function automatic bit deframe_header(logic [7:0] b, output cfd_out_t r);
        logic [2:0] idx;
        idx = hdr_idx;
        r   = '0;
        case (idx)
            IDX_LEN_HI: frame_len[15:8] = b;
            IDX_LEN_LO: frame_len[7:0]  = b;
            IDX_TYPE_C: if (b != TYPE_CHAR) type_good = 1'b0;
            IDX_TYPE_A, IDX_TYPE_B: if (b != TYPE_ONE) type_good = 1'b0;
            default: ;
        endcase
        hdr_idx = idx + 3'd1;
        if (idx != HEADER_LAST_IDX)
            return 1'b0;
        if (!type_good)
        begin
            frame_restart();
            r = end_result(ST_BAD_TYPE);
            return 1'b1;
        end
        if (frame_len <= LENGTH_OVERHEAD)
        begin
            frame_restart();
            r = end_result(ST_OK);
            return 1'b1;
        end
        pay_left = frame_len - LENGTH_OVERHEAD;
        ph       = FR_PAYLOAD;
        return 1'b0;
    endfunction

    // Advance the shadow deframer by one transaction; 1 when a result is due
    function automatic bit deframe_byte(cfd_in_t it, output cfd_out_t r);
        logic [7:0] b;
        b = it.rx_byte;
        r = '0;
        if (it.operation == OP_TIMER)
        begin
            case (ph)
                FR_HEADER:  r = end_result(ST_HEADER_TO);
                FR_PAYLOAD: r = end_result(ST_PAYLOAD_TO);
                default:    r = end_result(ST_LEADER_TO);
            endcase
            frame_restart();
            return 1'b1;
        end
        if (ph == FR_HEADER)
            return deframe_header(b, r);
        if (ph == FR_PAYLOAD)
        begin
            r.has_byte  = 1'b1;
            r.data_byte = b;
            r.status    = ST_OK;
            if (pay_left <= 16'd1)
            begin
                frame_restart();
                r.last = 1'b1;
            end
            else
            begin
                pay_left = pay_left - 16'd1;
                r.last   = 1'b0;
            end
            return 1'b1;
        end
        // leader phase
        if (b == LEADER_CHAR)
        begin
            lead_cnt = lead_cnt + 2'd1;
            if (lead_cnt >= LEADER_MAX)
            begin
                ph      = FR_HEADER;
                hdr_idx = 3'd0;
            end
            return 1'b0;
        end
        if (lead_cnt == 2'd0)
        begin
            frame_restart();
            r = end_result(ST_NO_LEADER);
            return 1'b1;
        end
        ph      = FR_HEADER;
        hdr_idx = 3'd0;
        return deframe_header(b, r);
    endfunction

    function automatic void count_error(string msg);
        n_bad++;
        if (n_bad <= REPORT_MAX)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    function automatic void add_row(op_t op, logic [7:0] b, bit fixed, status_t st);
        dir_row_t row;
        row.item   = mk_item(op, b);
        row.fixed  = fixed;
        row.result = end_result(st);
        dir_tab.push_back(row);
    endfunction

    // Offer one transaction, optionally after an idle burst; returns at a falling edge
    task automatic drive_item(cfd_in_t it, bit fixed, cfd_out_t fixed_out);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid      = 1'b1;
        in_data       = it;
        row_fixed     = fixed;
        row_fixed_out = fixed_out;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        n_sent++;
        if (n_sent == HOLD_AT)
            hold_req = 1'b1;
        // let every pending result drain before going on
        if (n_sent == PAUSE_AT)
        begin
            in_valid = 1'b0;
            while (deframed_q.size() != 0)
                @(negedge clk);
        end
        if (n_sent >= ITEMS - CALM_TAIL)
            calm = 1'b1;
    endtask

    // Mostly well-formed frames with random content; some broken or cut by the timer
    task automatic send_random_frame();
        cfd_in_t     seq[$];
        int          n_lead;
        int          sel;
        int          n_pay;
        int          cut;
        bit          abort;
        logic [15:0] len;
        logic [7:0]  crc0;
        logic [7:0]  ty[3];
        n_lead = $urandom_range(1, 3);
        repeat (n_lead) seq.push_back(mk_item(OP_BYTE, LEADER_CHAR));
        crc0 = 8'($urandom_range(0, 255));
        if (n_lead < 3 && crc0 == LEADER_CHAR)
            crc0 = ~crc0;
        abort = 1'b0;
        sel   = $urandom_range(0, 99);
        if (sel < 12)
            len = 16'($urandom_range(0, 5));
        else if (sel < 88)
            len = 16'($urandom_range(6, 24));
        else
        begin
            // long frame, ended by the timer after at most 12 payload bytes
            len   = 16'($urandom_range(256, 65535));
            abort = 1'b1;
        end
        ty[0] = TYPE_CHAR;
        ty[1] = TYPE_ONE;
        ty[2] = TYPE_ONE;
        if ($urandom_range(0, 9) == 0)
            ty[$urandom_range(0, 2)] = 8'($urandom_range(0, 255));
        seq.push_back(mk_item(OP_BYTE, crc0));
        seq.push_back(mk_item(OP_BYTE, 8'($urandom_range(0, 255))));
        seq.push_back(mk_item(OP_BYTE, len[15:8]));
        seq.push_back(mk_item(OP_BYTE, len[7:0]));
        foreach (ty[i]) seq.push_back(mk_item(OP_BYTE, ty[i]));
        n_pay = (len > LENGTH_OVERHEAD) ? int'(len - LENGTH_OVERHEAD) : 0;
        if (abort)
            n_pay = $urandom_range(0, 12);
        repeat (n_pay) seq.push_back(mk_item(OP_BYTE, 8'($urandom_range(0, 255))));
        // truncated frame
        if (!abort && $urandom_range(0, 15) == 0)
        begin
            cut = $urandom_range(1, seq.size() - 1);
            while (seq.size() > cut)
                void'(seq.pop_back());
            abort = 1'b1;
        end
        if (abort)
            seq.push_back(mk_item(OP_TIMER, 8'($urandom_range(0, 255))));
        foreach (seq[i]) drive_item(seq[i], 1'b0, '0);
    endtask

    // Output check first, then prediction for the transaction accepted at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (deframed_q.size() == 0)
                    count_error($sformatf("unexpected result has_byte %0d data %02h last %0d st %0d",
                        out_data.has_byte, out_data.data_byte, out_data.last, out_data.status));
                else
                begin
                    head_out = deframed_q.pop_front();
                    if (out_data.has_byte !== head_out.has_byte
                        || out_data.data_byte !== head_out.data_byte
                        || out_data.last !== head_out.last
                        || out_data.status !== head_out.status)
                        count_error($sformatf(
                            "mismatch exp/act: has_byte %0d/%0d data %02h/%02h last %0d/%0d st %0d/%0d",
                            head_out.has_byte, out_data.has_byte,
                            head_out.data_byte, out_data.data_byte,
                            head_out.last, out_data.last,
                            head_out.status, out_data.status));
                end
            end
            if (in_valid && in_ready)
            begin
                step_has = deframe_byte(in_data, step_out);
                if (row_fixed)
                    deframed_q.push_back(row_fixed_out);
                else if (step_has)
                    deframed_q.push_back(step_out);
            end
        end
        else
        begin
            frame_restart();
        end
    end

    // Watchdog: cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles <= 0;
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles == STUCK_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off, none in the tail
    initial
    begin
        out_ready = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            else
            begin
                out_ready = 1'b1;
                @(negedge clk);
            end
        end
    end

    // Sender
    initial
    begin
        in_valid      = 1'b0;
        in_data       = '0;
        row_fixed     = 1'b0;
        row_fixed_out = '0;
        n_sent        = 0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        rst_n = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // timer with nothing received, then a byte with no leader
        add_row(OP_TIMER, 8'h00, 1'b1, ST_LEADER_TO);
        add_row(OP_BYTE, 8'hFF, 1'b1, ST_NO_LEADER);
        // full leader, '@' taken as CRC, length below overhead: empty payload
        add_row(OP_BYTE, LEADER_CHAR, 1'b0, ST_OK);
        add_row(OP_BYTE, LEADER_CHAR, 1'b0, ST_OK);
        add_row(OP_BYTE, LEADER_CHAR, 1'b0, ST_OK);
        add_row(OP_BYTE, LEADER_CHAR, 1'b0, ST_OK);
        add_row(OP_BYTE, 8'hFF, 1'b0, ST_OK);
        add_row(OP_BYTE, 8'h00, 1'b0, ST_OK);
        add_row(OP_BYTE, 8'h03, 1'b0, ST_OK);
        add_row(OP_BYTE, TYPE_CHAR, 1'b0, ST_OK);
        add_row(OP_BYTE, TYPE_ONE, 1'b0, ST_OK);
        add_row(OP_BYTE, TYPE_ONE, 1'b1, ST_OK);
        // short leader, timer in the header
        add_row(OP_BYTE, LEADER_CHAR, 1'b0, ST_OK);
        add_row(OP_BYTE, 8'h00, 1'b0, ST_OK);
        add_row(OP_TIMER, 8'hFF, 1'b1, ST_HEADER_TO);
        // two-byte leader, maximum length, bad last type byte
        add_row(OP_BYTE, LEADER_CHAR, 1'b0, ST_OK);
        add_row(OP_BYTE, LEADER_CHAR, 1'b0, ST_OK);
        add_row(OP_BYTE, 8'h00, 1'b0, ST_OK);
        add_row(OP_BYTE, 8'h00, 1'b0, ST_OK);
        add_row(OP_BYTE, 8'hFF, 1'b0, ST_OK);
        add_row(OP_BYTE, 8'hFF, 1'b0, ST_OK);
        add_row(OP_BYTE, TYPE_CHAR, 1'b0, ST_OK);
        add_row(OP_BYTE, TYPE_ONE, 1'b0, ST_OK);
        add_row(OP_BYTE, 8'h00, 1'b1, ST_BAD_TYPE);

        foreach (dir_tab[i]) drive_item(dir_tab[i].item, dir_tab[i].fixed, dir_tab[i].result);

        // random frames with occasional stray bytes and timer hits between them
        while (n_sent < ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
                drive_item(mk_item(op_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255))),
                    1'b0, '0);
            else
                send_random_frame();
        end
        in_valid = 1'b0;

        while (deframed_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (n_bad == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/cfd_pkg.sv
sv/cfd_in_stage.sv
sv/cfd_core.sv
sv/cfd_out_stage.sv
sv/command_frame_deframer_unit.sv
tb/tb_top.sv
